### rtl/core/psu_pkg.sv
// Shared constants, types and filter codes for the PNG scanline unfilter block.
`default_nettype none
package psu_pkg;

	// Line store geometry
	localparam int MAX_WIDTH = 4096;
	localparam int COL_W     = $clog2(MAX_WIDTH);

	// Field widths fixed by the stream format
	localparam int CFG_W  = 13;
	localparam int CH_W   = 8;
	localparam int NUM_CH = 4;
	localparam int PIX_W  = CH_W * NUM_CH;
	localparam int FB_W   = 8;

	// Largest legal filter code
	localparam logic [FB_W-1:0] FB_MAX = 8'd4;

	// Row width limits in register units
	localparam logic [CFG_W-1:0] WIDTH_MAX = CFG_W'(MAX_WIDTH);

	// Filter codes
	typedef enum logic [2:0] {
		FLT_NONE  = 3'd0,
		FLT_SUB   = 3'd1,
		FLT_UP    = 3'd2,
		FLT_AVG   = 3'd3,
		FLT_PAETH = 3'd4
	} flt_t;

	// Per-item control carried from the accept stage into the rebuild stage
	typedef struct packed {
		flt_t             flt;
		logic             bad;
		logic             first_row;
		logic             col0;
		logic             last;
		logic             fwd;
		logic [COL_W-1:0] col;
	} s1_ctl_t;

endpackage
`default_nettype wire

### rtl/core/psu_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module psu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

### rtl/core/psu_lane.sv
// One channel of filter reconstruction: predictor selection and modulo-256 add.
`default_nettype none
module psu_lane
	import psu_pkg::*;
(
	input  flt_t            flt,
	input  wire [CH_W-1:0]  raw,
	input  wire [CH_W-1:0]  a,
	input  wire [CH_W-1:0]  b,
	input  wire [CH_W-1:0]  c,
	output logic [CH_W-1:0] pix
);

	logic signed [CH_W+1:0] pa;
	logic signed [CH_W+1:0] pb;
	logic signed [CH_W+1:0] pc;
	logic signed [CH_W+1:0] da;
	logic signed [CH_W+1:0] db;
	logic signed [CH_W+1:0] dc;
	logic [CH_W-1:0]        paeth;
	logic [CH_W:0]          avg_sum;
	logic [CH_W-1:0]        pred;

	// Paeth distances: |b-c|, |a-c|, |a+b-2c|
	always_comb begin
		da = $signed({2'b00, b}) - $signed({2'b00, c});
		db = $signed({2'b00, a}) - $signed({2'b00, c});
		dc = da + db;
		pa = (da < 0) ? -da : da;
		pb = (db < 0) ? -db : db;
		pc = (dc < 0) ? -dc : dc;
		priority if (pa <= pb && pa <= pc) begin
			paeth = a;
		end else if (pb <= pc) begin
			paeth = b;
		end else begin
			paeth = c;
		end
	end

	assign avg_sum = {1'b0, a} + {1'b0, b};

	// Predictor select; unknown codes never reach here but decode as None
	always_comb begin
		case (flt)
			FLT_SUB:   pred = a;
			FLT_UP:    pred = b;
			FLT_AVG:   pred = avg_sum[CH_W:1];
			FLT_PAETH: pred = paeth;
			default:   pred = '0;
		endcase
	end

	assign pix = raw + pred;

endmodule
`default_nettype wire

### rtl/core/png_scanline_unfilter_rgba8.sv
// PNG scanline filter reconstruction for RGBA8, one pixel per unstalled cycle.
//
// Usage:
//  - Input stream s_*: one filtered pixel per request. s_tdata holds the four
//    filtered channel bytes, s_tuser the row filter byte and an image start flag.
//    The filter byte is sampled on the first pixel of each row.
//  - Output stream m_*: one rebuilt pixel per request, m_tlast on the last pixel
//    of each scanline, m_tuser flags a row whose filter byte was above 4 (that
//    row decodes as None).
//  - cfg_we/cfg_wdata set the row width; write it only while the block is idle.
//    A width of 0 acts as 1, widths above 4096 act as 4096.
//  - Each request moves from the accept stage, with its line store read, into
//    the rebuild stage, then from the rebuild stage into the output register;
//    a stalled output holds the rebuild stage.
//    Throughput: one pixel per cycle while m_tready stays high, set by the
//    left-pixel feedback in the rebuild stage.
//  - Reset clears the pipeline, the row state and sets the width to 1. The line
//    store is not cleared: the first row of each image reads zero above.
//  - When m_tready is low the output register holds, then the rebuild stage
//    holds, and s_tready drops; no request is lost or repeated.
`default_nettype none
module png_scanline_unfilter_rgba8
	import psu_pkg::*;
(
	input  wire              clk,
	input  wire              arst_n,
	input  wire              cfg_we,
	input  wire [CFG_W-1:0]  cfg_wdata,  // row_width
	input  wire              s_tvalid,
	output logic             s_tready,
	input  wire [31:0]       s_tdata,    // raw_red, raw_green, raw_blue, raw_alpha
	input  wire [15:0]       s_tuser,    // filter_byte[7:0], image_start[8], zero pad
	output logic             m_tvalid,
	input  wire              m_tready,
	output logic [31:0]      m_tdata,    // red, green, blue, alpha
	output logic             m_tlast,    // row_end
	output logic [7:0]       m_tuser     // bad_filter[0], zero pad
);

	logic [CFG_W-1:0] row_width_q;
	logic [COL_W-1:0] col_q;
	logic             first_row_q;
	flt_t             flt_q;
	logic             bad_q;

	logic             s_acc;
	logic             s1_fire;
	logic             s1_valid_q;
	s1_ctl_t          ctl_s1;
	s1_ctl_t          ctl_in;
	logic [PIX_W-1:0] raw_s1;
	logic [PIX_W-1:0] fwd_pix_s1;

	logic             start;
	logic [FB_W-1:0]  fb;
	logic [CFG_W-1:0] eff_w;
	logic [CFG_W-1:0] col_inc;
	logic             fb_bad;

	logic [PIX_W-1:0] ram_rdata;
	logic [PIX_W-1:0] above;
	logic [PIX_W-1:0] left_q;
	logic [PIX_W-1:0] ul_q;
	logic [PIX_W-1:0] a_pix;
	logic [PIX_W-1:0] c_pix;
	logic [PIX_W-1:0] pix;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= CFG_W'(1);
		end else if (cfg_we) begin
			row_width_q <= cfg_wdata;
		end
	end

	// Effective row width
	always_comb begin
		priority if (row_width_q == '0) begin
			eff_w = CFG_W'(1);
		end else if (row_width_q > WIDTH_MAX) begin
			eff_w = WIDTH_MAX;
		end else begin
			eff_w = row_width_q;
		end
	end

	// Handshake
	assign s1_fire  = s1_valid_q && (!m_tvalid || m_tready);
	assign s_tready = !s1_valid_q || s1_fire;
	assign s_acc    = s_tvalid && s_tready;

	// Accept stage: column sequencing and row filter capture
	assign start  = s_tuser[8];
	assign fb     = s_tuser[7:0];
	assign fb_bad = fb > FB_MAX;

	always_comb begin
		ctl_in.col       = start ? '0 : col_q;
		ctl_in.first_row = start ? 1'b1 : first_row_q;
		ctl_in.col0      = (ctl_in.col == '0);
		if (ctl_in.col0) begin
			ctl_in.flt = fb_bad ? FLT_NONE : flt_t'(fb[2:0]);
			ctl_in.bad = fb_bad;
		end else begin
			ctl_in.flt = flt_q;
			ctl_in.bad = bad_q;
		end
		col_inc     = CFG_W'(ctl_in.col) + CFG_W'(1);
		ctl_in.last = col_inc >= eff_w;
		// Same-cycle write of the entry being read: take the value being written
		ctl_in.fwd  = s1_fire && (ctl_s1.col == ctl_in.col);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			first_row_q <= 1'b1;
			flt_q       <= FLT_NONE;
			bad_q       <= 1'b0;
		end else if (s_acc) begin
			col_q       <= ctl_in.last ? '0 : col_inc[COL_W-1:0];
			first_row_q <= ctl_in.last ? 1'b0 : ctl_in.first_row;
			flt_q       <= ctl_in.flt;
			bad_q       <= ctl_in.bad;
		end
	end

	// Rebuild stage registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			ctl_s1     <= ctl_in;
			raw_s1     <= s_tdata;
			fwd_pix_s1 <= pix;
		end
	end

	// Line store of the previous row
	psu_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.we    (s1_fire),
		.waddr (ctl_s1.col),
		.wdata (pix),
		.re    (s_acc),
		.raddr (ctl_in.col),
		.rdata (ram_rdata)
	);

	// Neighbor selection
	always_comb begin
		if (ctl_s1.first_row) begin
			above = '0;
		end else if (ctl_s1.fwd) begin
			above = fwd_pix_s1;
		end else begin
			above = ram_rdata;
		end
		a_pix = ctl_s1.col0 ? '0 : left_q;
		c_pix = ctl_s1.col0 ? '0 : ul_q;
	end

	// Channel lanes; their output bytes pack back into one pixel
	for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
		psu_lane u_lane (
			.flt (ctl_s1.flt),
			.raw (raw_s1[ch*CH_W +: CH_W]),
			.a   (a_pix[ch*CH_W +: CH_W]),
			.b   (above[ch*CH_W +: CH_W]),
			.c   (c_pix[ch*CH_W +: CH_W]),
			.pix (pix[ch*CH_W +: CH_W])
		);
	end

	// Left and upper-left history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			ul_q   <= '0;
		end else if (s1_fire) begin
			left_q <= pix;
			ul_q   <= above;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (s1_fire) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			m_tdata <= pix;
			m_tlast <= ctl_s1.last;
			m_tuser <= {7'd0, ctl_s1.bad};
		end
	end

endmodule
`default_nettype wire

### rtl/core/psu_checker.sv
// Port-level checks for the scanline unfilter block, bound to the top level.
`default_nettype none
module psu_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [31:0] m_tdata,
	input wire        m_tlast,
	input wire [7:0]  m_tuser
);

	logic [2:0] inflight_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// Requests accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + {2'd0, in_acc} - {2'd0, out_acc};
		end
	end

	// A stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
		&& $stable(m_tuser))
		else $error("stalled result changed");

	// Input backpressure only comes from a stalled output
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

	// No result without a pending request
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> inflight_q != 3'd0)
		else $error("result delivered with nothing pending");

	// At most two requests in flight: rebuild stage plus output register
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 3'd2)
		else $error("too many requests in flight");

endmodule

bind png_scanline_unfilter_rgba8 psu_checker u_psu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
`default_nettype wire
